/* src/date_to_rtc_bcd_with_weekday_unit_defines.svh */
// assertion macros shared by the date to rtc bcd unit
// no dependencies; taken in by `include where assertions are written
`ifndef DATE_TO_RTC_BCD_WITH_WEEKDAY_UNIT_DEFINES_SVH
`define DATE_TO_RTC_BCD_WITH_WEEKDAY_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define DTRB_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("dtrb assertion failed");
// next-cycle implication, checked out of reset
`define DTRB_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("dtrb assertion failed");
`else
`define DTRB_ASSERT_IMP(lbl, pre, post)
`define DTRB_ASSERT_NXT(lbl, pre, post)
`endif

`endif

/* src/dtrb_pkg.sv */
// types, tables and small functions for the date to rtc bcd unit
// no dependencies; used by every module of the unit
package dtrb_pkg;

  // fields of one input transfer
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [13:0] year;
  } in_t;

  // after stage 1: quotients by 100, month offset, small bcd fields
  typedef struct packed {
    logic [13:0] year;
    logic [14:0] prev;
    logic [14:0] y;
    logic [7:0]  year_q;
    logic [7:0]  prev_q;
    logic [7:0]  y_q;
    logic [8:0]  ms;
    logic        m_gt2;
    logic [4:0]  day;
    logic [4:0]  month_bcd;
    logic [5:0]  date_bcd;
    logic [5:0]  hour_bcd;
    logic [6:0]  minute_bcd;
    logic [6:0]  second_bcd;
  } s1_t;

  // after stage 2: remainders, leap count, partial day count
  typedef struct packed {
    logic [6:0]  year_rem;
    logic [6:0]  cent_rem;
    logic        cw;
    logic [12:0] leaps;
    logic        adj;
    logic [14:0] part;
    logic [4:0]  month_bcd;
    logic [5:0]  date_bcd;
    logic [5:0]  hour_bcd;
    logic [6:0]  minute_bcd;
    logic [6:0]  second_bcd;
  } s2_t;

  // after stage 3: folded day count, year and century digits
  typedef struct packed {
    logic [5:0]  fold;
    logic [7:0]  year_bcd;
    logic [7:0]  century_bcd;
    logic        cw;
    logic [4:0]  month_bcd;
    logic [5:0]  date_bcd;
    logic [5:0]  hour_bcd;
    logic [6:0]  minute_bcd;
    logic [6:0]  second_bcd;
  } s3_t;

  // one result transfer
  typedef struct packed {
    logic [7:0]  year_bcd;
    logic [7:0]  century_bcd;
    logic        century_write;
    logic [4:0]  month_bcd;
    logic [5:0]  date_bcd;
    logic [2:0]  weekday;
    logic [5:0]  hour_bcd;
    logic [6:0]  minute_bcd;
    logic [6:0]  second_bcd;
  } out_t;

  // reciprocal of 100 scaled by 2^19, exact for values below 43699
  localparam logic [12:0] RECIP100 = 13'd5243;
  localparam int          RECIP100_SHIFT = 19;

  // days before the first of each month in a common year; bad months as january
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // two bcd digits of a value below 100; tens by a row of compares
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] units;
    tens = 4'd0;
    for (int k = 1; k <= 12; k++) begin
      tens = tens + 4'(v >= 7'(10 * k));
    end
    units = v - 7'(tens) * 7'd10;
    return {tens, units[3:0]};
  endfunction

endpackage

/* src/dtrb_prep.sv */
// stage 1: quotients by 100, month offset and bcd of the small fields
// depends on dtrb_pkg
module dtrb_prep (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  input  dtrb_pkg::in_t up_data,
  output logic          up_ready,
  input  logic          down_ready,
  output logic          valid_r,
  output dtrb_pkg::s1_t data_r
);

  dtrb_pkg::s1_t data_nxt;
  logic [26:0]   year_prod;
  logic [27:0]   prev_prod;
  logic [27:0]   y_prod;

  assign up_ready = !valid_r || down_ready;

  always_comb begin
    data_nxt      = '0;
    data_nxt.year = up_data.year;
    data_nxt.prev = 15'(up_data.year) + 15'd399;
    data_nxt.y    = 15'(up_data.year) + 15'd400;
    year_prod     = 27'(up_data.year) * 27'(dtrb_pkg::RECIP100);
    prev_prod     = 28'(data_nxt.prev) * 28'(dtrb_pkg::RECIP100);
    y_prod        = 28'(data_nxt.y) * 28'(dtrb_pkg::RECIP100);
    data_nxt.year_q = year_prod[26:19];
    data_nxt.prev_q = prev_prod[26:19];
    data_nxt.y_q    = y_prod[26:19];
    data_nxt.ms     = dtrb_pkg::month_start(up_data.month);
    data_nxt.m_gt2  = (up_data.month > 4'd2) && (up_data.month <= 4'd12);
    data_nxt.day    = up_data.day_of_month;
    data_nxt.month_bcd  = 5'(dtrb_pkg::to_bcd(7'(up_data.month)));
    data_nxt.date_bcd   = 6'(dtrb_pkg::to_bcd(7'(up_data.day_of_month)));
    data_nxt.hour_bcd   = 6'(dtrb_pkg::to_bcd(7'(up_data.hour)));
    data_nxt.minute_bcd = 7'(dtrb_pkg::to_bcd(7'(up_data.minute)));
    data_nxt.second_bcd = 7'(dtrb_pkg::to_bcd(7'(up_data.second)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* src/dtrb_reduce.sv */
// stage 2: remainders by 100, leap year rule, leap count and partial day count
// depends on dtrb_pkg
module dtrb_reduce (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  input  dtrb_pkg::s1_t up_data,
  output logic          up_ready,
  input  logic          down_ready,
  output logic          valid_r,
  output dtrb_pkg::s2_t data_r
);

  dtrb_pkg::s2_t data_nxt;
  logic [15:0]   y_hund;
  logic [13:0]   year_hund;
  logic          div100;
  logic          leap;

  assign up_ready = !valid_r || down_ready;

  always_comb begin
    data_nxt  = '0;
    year_hund = 14'(up_data.year_q) * 14'd100;
    data_nxt.year_rem = 7'(up_data.year - year_hund);
    // year / 100 stays below 200, so one subtract reduces it mod 100
    data_nxt.cent_rem = (up_data.year_q >= 8'd100) ? 7'(up_data.year_q - 8'd100)
                                                   : up_data.year_q[6:0];
    data_nxt.cw = (up_data.year_q != 8'd0);
    y_hund = 16'(up_data.y_q) * 16'd100;
    div100 = (16'(up_data.y) == y_hund);
    leap   = (up_data.y[1:0] == 2'd0) && (!div100 || (up_data.y_q[1:0] == 2'd0));
    data_nxt.adj = leap && up_data.m_gt2;
    // prev/4 - prev/100 + prev/400
    data_nxt.leaps = up_data.prev[14:2] - 13'(up_data.prev_q) + 13'(up_data.prev_q[7:2]);
    // 365 is 1 mod 7, so prev stands in for prev * 365
    data_nxt.part = up_data.prev + 15'(up_data.ms) + 15'(up_data.day);
    data_nxt.month_bcd  = up_data.month_bcd;
    data_nxt.date_bcd   = up_data.date_bcd;
    data_nxt.hour_bcd   = up_data.hour_bcd;
    data_nxt.minute_bcd = up_data.minute_bcd;
    data_nxt.second_bcd = up_data.second_bcd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* src/dtrb_weekday.sv */
// stages 3 and 4: day count mod 7 by octal digit folding, year and century bcd
// depends on dtrb_pkg; stage 4 is the output register
module dtrb_weekday (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  input  dtrb_pkg::s2_t  up_data,
  output logic           up_ready,
  input  logic           down_ready,
  output logic           valid_r,
  output dtrb_pkg::out_t data_r
);

  dtrb_pkg::s3_t  mid_nxt;
  dtrb_pkg::s3_t  mid_r;
  logic           mid_valid_r;
  logic           mid_ready;
  logic [14:0]    count;
  dtrb_pkg::out_t data_nxt;
  logic [3:0]     f2;
  logic [2:0]     md;

  assign mid_ready = !valid_r || down_ready;
  assign up_ready  = !mid_valid_r || mid_ready;

  // stage 3: full count and first fold, 8 is 1 mod 7
  always_comb begin
    mid_nxt = '0;
    count   = up_data.part + 15'(up_data.leaps) + 15'(up_data.adj);
    mid_nxt.fold = 6'(count[2:0]) + 6'(count[5:3]) + 6'(count[8:6])
                 + 6'(count[11:9]) + 6'(count[14:12]);
    mid_nxt.year_bcd    = dtrb_pkg::to_bcd(up_data.year_rem);
    mid_nxt.century_bcd = dtrb_pkg::to_bcd(up_data.cent_rem);
    mid_nxt.cw          = up_data.cw;
    mid_nxt.month_bcd   = up_data.month_bcd;
    mid_nxt.date_bcd    = up_data.date_bcd;
    mid_nxt.hour_bcd    = up_data.hour_bcd;
    mid_nxt.minute_bcd  = up_data.minute_bcd;
    mid_nxt.second_bcd  = up_data.second_bcd;
  end

  // stage 4: second fold, final reduce, sunday is 1
  always_comb begin
    data_nxt = '0;
    f2 = 4'(mid_r.fold[2:0]) + 4'(mid_r.fold[5:3]);
    md = (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
    data_nxt.weekday       = md + 3'd1;
    data_nxt.year_bcd      = mid_r.year_bcd;
    data_nxt.century_bcd   = mid_r.century_bcd;
    data_nxt.century_write = mid_r.cw;
    data_nxt.month_bcd     = mid_r.month_bcd;
    data_nxt.date_bcd      = mid_r.date_bcd;
    data_nxt.hour_bcd      = mid_r.hour_bcd;
    data_nxt.minute_bcd    = mid_r.minute_bcd;
    data_nxt.second_bcd    = mid_r.second_bcd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      if (up_ready) begin
        mid_valid_r <= up_valid;
      end
      if (mid_ready) begin
        valid_r <= mid_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      mid_r <= mid_nxt;
    end
    if (mid_ready && mid_valid_r) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* src/date_to_rtc_bcd_with_weekday_unit.sv */
// date to rtc bcd unit: binary calendar date and time in, rtc register image out.
// one result per input transfer; a new date is accepted every cycle unless the
// output side holds off results and the stages fill. the four register stages
// are: quotients by 100 (reciprocal multipliers), remainders and leap count,
// day count with a first mod 7 fold, and the final weekday reduce in the output
// register. each stage stalls only when it holds an item that the next stage
// cannot take, so bubbles close up and a waiting result does not block new
// input while earlier stages have room.
// the weekday follows the proleptic gregorian calendar (1 sunday .. 7 saturday);
// century digits are (year / 100) mod 100 and out_tuser flags years of 100 or
// more. out-of-range months give january weekdays; other fields encode as given.
// depends on dtrb_pkg, dtrb_prep, dtrb_reduce, dtrb_weekday and the defines header
`include "date_to_rtc_bcd_with_weekday_unit_defines.svh"

module date_to_rtc_bcd_with_weekday_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // year[13:0], month[17:14], day_of_month[22:18], hour[27:23], minute[33:28],
  // second[39:34]
  input  logic [39:0] in_tdata,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // year_bcd[7:0], century_bcd[15:8], month_bcd[20:16], date_bcd[26:21],
  // weekday[29:27], hour_bcd[35:30], minute_bcd[42:36], second_bcd[49:43],
  // zero fill[55:50]
  output logic [55:0] out_tdata,
  // century_write[0]
  output logic [0:0]  out_tuser
);

  dtrb_pkg::in_t  in_item;
  dtrb_pkg::s1_t  s1_data;
  dtrb_pkg::s2_t  s2_data;
  dtrb_pkg::out_t res;
  logic           s1_valid;
  logic           s2_valid;
  logic           s2_ready;
  logic           s3_ready;

  // unpack the input transfer, first field in the low bits
  assign in_item = dtrb_pkg::in_t'(in_tdata);

  // stage 1
  dtrb_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_tvalid),
    .up_data    (in_item),
    .up_ready   (in_tready),
    .down_ready (s2_ready),
    .valid_r    (s1_valid),
    .data_r     (s1_data)
  );

  // stage 2
  dtrb_reduce u_reduce (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (s1_valid),
    .up_data    (s1_data),
    .up_ready   (s2_ready),
    .down_ready (s3_ready),
    .valid_r    (s2_valid),
    .data_r     (s2_data)
  );

  // stages 3 and 4, the last one drives the output ports
  dtrb_weekday u_weekday (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (s2_valid),
    .up_data    (s2_data),
    .up_ready   (s3_ready),
    .down_ready (out_tready),
    .valid_r    (out_tvalid),
    .data_r     (res)
  );

  // pack the result transfer, first field in the low bits
  assign out_tdata = {6'd0, res.second_bcd, res.minute_bcd, res.hour_bcd, res.weekday,
                      res.date_bcd, res.month_bcd, res.century_bcd, res.year_bcd};
  assign out_tuser = res.century_write;

  // with nothing held at the output, no stage may push back on the input
  `DTRB_ASSERT_IMP(a_no_stall_when_empty, !out_tvalid, in_tready)
  // an accepted transfer lands in stage 1 on the next edge
  `DTRB_ASSERT_NXT(a_accept_to_stage1, in_tvalid && in_tready, s1_valid)
  // weekday is never zero
  `DTRB_ASSERT_IMP(a_weekday_nonzero, out_tvalid, out_tdata[29:27] != 3'd0)
  // year and century units digits are decimal
  `DTRB_ASSERT_IMP(a_units_decimal, out_tvalid,
                   (out_tdata[3:0] <= 4'd9) && (out_tdata[11:8] <= 4'd9))

endmodule

/* sim/date_to_rtc_bcd_with_weekday_unit_tb.sv */
// self-checking bench for the date to rtc bcd unit: dates go in, rtc register images come out
// depends on dtrb_pkg for the input transfer layout and on date_to_rtc_bcd_with_weekday_unit
`timescale 1ns / 100ps

// one expected register image, century flag included
typedef struct packed {
  logic [7:0] year_bcd;
  logic [7:0] century_bcd;
  logic       century_write;
  logic [4:0] month_bcd;
  logic [5:0] date_bcd;
  logic [2:0] weekday;
  logic [5:0] hour_bcd;
  logic [6:0] minute_bcd;
  logic [6:0] second_bcd;
} rtc_image_t;

class rtc_image_scoreboard;
  rtc_image_t  pending_images[$];
  int unsigned mismatches = 0;

  // tens digit wraps mod 10, as the rtc fields only hold two digits
  function automatic logic [7:0] bcd_pair(int unsigned v);
    return {4'((v / 10) % 10), 4'(v % 10)};
  endfunction

  // proleptic gregorian day count mod 7, 1 sunday .. 7 saturday
  function automatic logic [2:0] weekday_of(int unsigned yr, int unsigned mo,
                                            int unsigned dd);
    int unsigned cum_days[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    int unsigned shifted, last_year, mon, days;
    bit          is_leap;
    shifted   = yr + 400;  // keeps year zero positive, same weekday cycle
    last_year = shifted - 1;
    mon       = (mo >= 1 && mo <= 12) ? mo : 1;
    is_leap   = (shifted % 4 == 0) && ((shifted % 100 != 0) || (shifted % 400 == 0));
    days      = last_year * 365 + last_year / 4 - last_year / 100 + last_year / 400
                + cum_days[mon - 1] + dd;
    if (is_leap && mon > 2) days++;
    return 3'(days % 7 + 1);
  endfunction

  function automatic rtc_image_t image_of(dtrb_pkg::in_t d);
    rtc_image_t img;
    logic [7:0] b;
    img.year_bcd      = bcd_pair(d.year % 100);
    img.century_write = (d.year >= 100);
    img.century_bcd   = img.century_write ? bcd_pair(d.year / 100) : 8'd0;
    b = bcd_pair(d.month);        img.month_bcd  = b[4:0];
    b = bcd_pair(d.day_of_month); img.date_bcd   = b[5:0];
    b = bcd_pair(d.hour);         img.hour_bcd   = b[5:0];
    b = bcd_pair(d.minute);       img.minute_bcd = b[6:0];
    b = bcd_pair(d.second);       img.second_bcd = b[6:0];
    img.weekday = weekday_of(d.year, d.month, d.day_of_month);
    return img;
  endfunction

  function void note_date(dtrb_pkg::in_t d);
    pending_images.push_back(image_of(d));
  endfunction

  function int unsigned outstanding();
    return pending_images.size();
  endfunction

  function void field_check(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0h, actual %0h", name, want, got);
    end
  endfunction

  function void check_image(logic [55:0] data, logic cw);
    rtc_image_t want;
    if (pending_images.size() == 0) begin
      mismatches++;
      $error("result transfer with nothing expected, data %h", data);
      return;
    end
    want = pending_images.pop_front();
    field_check("year_bcd",      want.year_bcd,      data[7:0]);
    field_check("century_bcd",   want.century_bcd,   data[15:8]);
    field_check("century_write", want.century_write, cw);
    field_check("month_bcd",     want.month_bcd,     data[20:16]);
    field_check("date_bcd",      want.date_bcd,      data[26:21]);
    field_check("weekday",       want.weekday,       data[29:27]);
    field_check("hour_bcd",      want.hour_bcd,      data[35:30]);
    field_check("minute_bcd",    want.minute_bcd,    data[42:36]);
    field_check("second_bcd",    want.second_bcd,    data[49:43]);
  endfunction
endclass

module date_to_rtc_bcd_with_weekday_unit_tb;

  localparam int CLK_PERIOD   = 4;
  localparam int QUIET_LIMIT  = 4000;  // cycles with no transfer on either side
  localparam int PHASE_ITEMS  = 185;   // random dates per phase
  localparam int TAIL_CYCLES  = 12;    // pipeline is four deep, leave some slack

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [0:0]  out_tuser;

  // chance in percent, per cycle, that the sender holds off or the receiver stalls
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned quiet_cycles  = 0;

  rtc_image_scoreboard board = new;

  always #(CLK_PERIOD / 2) clk = ~clk;

  date_to_rtc_bcd_with_weekday_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // year, month, day_of_month, hour, minute, second
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // year_bcd, century_bcd, month_bcd, date_bcd, weekday,
                               // hour_bcd, minute_bcd, second_bcd, zero fill
    .out_tuser  (out_tuser)    // century_write
  );

  // receiver: fresh stall decision every cycle at the current stall rate
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // both sides are watched at the edge, so values seen are those that made the transfer;
  // the input side is noted first in case a result ever came out in the same cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (in_tvalid && in_tready) board.note_date(dtrb_pkg::in_t'(in_tdata));
      if (out_tvalid && out_tready) board.check_image(out_tdata, out_tuser[0]);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog: a hung handshake ends the run
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("date_to_rtc_bcd_with_weekday_unit_tb: errors");
    $finish;
  end

  function automatic dtrb_pkg::in_t date_of(int unsigned yr, int unsigned mo,
                                            int unsigned dd, int unsigned hh,
                                            int unsigned mi, int unsigned ss);
    dtrb_pkg::in_t d;
    d.year         = 14'(yr);
    d.month        = 4'(mo);
    d.day_of_month = 5'(dd);
    d.hour         = 5'(hh);
    d.minute       = 6'(mi);
    d.second       = 6'(ss);
    return d;
  endfunction

  // mostly calendar-valid dates, some near century edges, some with every field wild
  function automatic dtrb_pkg::in_t random_date();
    dtrb_pkg::in_t d;
    int unsigned   pick;
    bit            wild;
    pick = $urandom_range(99);
    wild = (pick < 15);
    if (wild)           d.year = 14'($urandom_range(16383));
    else if (pick < 30) d.year = 14'($urandom_range(1, 99) * 100 - 1 + $urandom_range(2));
    else                d.year = 14'($urandom_range(1, 9999));
    d.month        = 4'(wild ? $urandom_range(15) : $urandom_range(1, 12));
    d.day_of_month = 5'(wild ? $urandom_range(31) : $urandom_range(1, 31));
    d.hour         = 5'(wild ? $urandom_range(31) : $urandom_range(23));
    d.minute       = 6'(wild ? $urandom_range(63) : $urandom_range(59));
    d.second       = 6'(wild ? $urandom_range(63) : $urandom_range(59));
    return d;
  endfunction

  // one input transfer; tvalid stays high when the next date follows at once
  task automatic send_date(input dtrb_pkg::in_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // sender holds off until every expected image has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int unsigned phase;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed dates: field extremes, leap rules, century flag edge, odd months and days
    send_date(date_of(1, 1, 1, 0, 0, 0));             // first day of the era
    send_date(date_of(9999, 12, 31, 23, 59, 59));     // last valid instant
    send_date(date_of(0, 2, 29, 12, 30, 30));         // year zero, a leap year
    send_date(date_of(0, 3, 1, 1, 2, 3));             // year zero after the leap day
    send_date(date_of(16383, 15, 31, 31, 63, 63));    // every input bit set
    send_date(date_of(99, 12, 31, 23, 59, 59));       // last year without century
    send_date(date_of(100, 1, 1, 0, 0, 0));           // century flag comes on
    send_date(date_of(1900, 2, 28, 6, 7, 8));         // century year, not leap
    send_date(date_of(1900, 3, 1, 9, 10, 11));
    send_date(date_of(2000, 2, 29, 12, 0, 0));        // four-hundred rule leap
    send_date(date_of(2000, 3, 1, 0, 0, 1));
    send_date(date_of(2024, 0, 5, 4, 5, 6));          // month zero counts as january
    send_date(date_of(2024, 13, 5, 4, 5, 6));
    send_date(date_of(2024, 14, 10, 4, 5, 6));
    send_date(date_of(2023, 6, 0, 0, 0, 0));          // day zero shifts the weekday back
    send_date(date_of(2023, 2, 31, 10, 20, 30));      // day past month end
    send_date(date_of(12000, 7, 4, 18, 45, 15));      // above 9999, century digits wrap
    send_date(date_of(1970, 1, 1, 0, 0, 0));
    send_date(date_of(2038, 1, 19, 3, 14, 7));
    send_date(date_of(1600, 12, 31, 22, 58, 57));
    send_date(date_of(1752, 9, 14, 0, 0, 0));

    // random phases: free flow, idle sender, stalling receiver, light idling on both
    for (phase = 0; phase < 4; phase++) begin
      drain_results();
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct    <= 0;
        end
        1: begin
          send_idle_pct = 51;
          stall_pct    <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct    <= 51;
        end
        default: begin
          send_idle_pct = 11;
          stall_pct    <= 11;
        end
      endcase
      repeat (PHASE_ITEMS) send_date(random_date());
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("date_to_rtc_bcd_with_weekday_unit_tb: clean");
    end else begin
      $display("date_to_rtc_bcd_with_weekday_unit_tb: errors");
    end
    $finish;
  end

endmodule
